/* design/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants for the sliding median filter.
// ----------------------------------------------------------------------------
package smf_pkg;

    localparam int MAX_HALF    = 15;
    localparam int SAMPLE_BITS = 16;
    localparam int DEPTH       = 2 * MAX_HALF + 1;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int H_W         = $clog2(MAX_HALF + 1);

    localparam logic [H_W-1:0] HALF_WIDTH_RST = H_W'(2);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // value moving from one sort cell to the next
    typedef struct packed {
        logic    valid;
        sample_t data;
    } link_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_MED,
        ST_PASS,
        ST_TAIL
    } state_t;

endpackage

/* design/smf_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_in_if
// Sample channel: valid/ready handshake carrying one sample per transaction.
// ----------------------------------------------------------------------------
interface smf_in_if;
    import smf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    end_of_signal;

    modport source (output valid, output sample, output end_of_signal, input ready);
    modport sink   (input valid, input sample, input end_of_signal, output ready);
endinterface

/* design/smf_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_out_if
// Result channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
interface smf_out_if;
    import smf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t value;
    logic    last_out;

    modport source (output valid, output value, output last_out, input ready);
    modport sink   (input valid, input value, input last_out, output ready);
endinterface

/* design/smf_sort_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_sort_cell
// One insertion cell: keeps the smaller of its value and the arriving one,
// hands the larger to the next cell.
// ----------------------------------------------------------------------------
module smf_sort_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  smf_pkg::link_t pass_in,
    output smf_pkg::link_t pass_out,
    output smf_pkg::sample_t held
);
    import smf_pkg::*;

    logic    full_reg;
    logic    full_next;
    sample_t held_reg;
    sample_t held_next;
    logic    pass_valid_reg;
    sample_t pass_data_reg;
    link_t   pass_next;

    always_comb
    begin
        full_next       = full_reg;
        held_next       = held_reg;
        pass_next.valid = 1'b0;
        pass_next.data  = pass_in.data;
        if (clear)
        begin
            full_next = 1'b0;
        end
        else if (pass_in.valid)
        begin
            if (!full_reg)
            begin
                full_next = 1'b1;
                held_next = pass_in.data;
            end
            else if (pass_in.data < held_reg)
            begin
                held_next       = pass_in.data;
                pass_next.valid = 1'b1;
                pass_next.data  = held_reg;
            end
            else
            begin
                pass_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg       <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg       <= full_next;
            pass_valid_reg <= pass_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        pass_data_reg <= pass_next.data;
    end

    assign pass_out = {pass_valid_reg, pass_data_reg};
    assign held     = held_reg;
endmodule

/* design/smf_sorter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_sorter
// Row of insertion cells; after a window has been fed and has settled, the
// cells hold it in ascending order and one rank is picked.
// ----------------------------------------------------------------------------
module smf_sorter
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  smf_pkg::link_t            feed,
    input  logic [smf_pkg::IDX_W-1:0] rank,
    output smf_pkg::sample_t          pick
);
    import smf_pkg::*;

    link_t   chain [DEPTH+1];
    sample_t held  [DEPTH];

    assign chain[0] = feed;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        smf_sort_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear),
            .pass_in  (chain[i]),
            .pass_out (chain[i+1]),
            .held     (held[i])
        );
    end

    assign pick = held[rank];
endmodule

/* design/smf_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smf_window
// Shift line of the most recent samples, newest at tap 0, one read tap.
// ----------------------------------------------------------------------------
module smf_window
(
    input  logic                      clk,
    input  logic                      shift_en,
    input  smf_pkg::sample_t          shift_data,
    input  logic [smf_pkg::IDX_W-1:0] rd_idx,
    output smf_pkg::sample_t          rd_data
);
    import smf_pkg::*;

    sample_t store_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            store_reg[0] <= shift_data;
            for (int k = 1; k < DEPTH; k++)
            begin
                store_reg[k] <= store_reg[k-1];
            end
        end
    end

    assign rd_data = store_reg[rd_idx];
endmodule

/* design/sliding_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median over a window of 2h+1 samples, pass-through near the ends
// of each signal, tail flushed on the last sample.
// ----------------------------------------------------------------------------
//  channel      dir  transaction
//  sample_ch    in   sample, end_of_signal
//  result_ch    out  value, last_out
//  cfg_we/wdata in   half_width write
//
//  One sample at a time. A median result feeds the window from its single read
//  tap into the cell row, lets the row settle, then loads the result. Tail
//  results are loaded one at a time after it. No clearing pass after reset.
//  A stalled result register holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module sliding_median_filter
(
    input  logic                    clk,
    input  logic                    rst_n,
    smf_in_if.sink                  sample_ch,
    smf_out_if.source               result_ch,
    input  logic                    cfg_we,
    input  logic [smf_pkg::H_W-1:0] cfg_wdata
);
    import smf_pkg::*;

    state_t           state_reg, state_next;
    logic [H_W-1:0]   half_width_reg;
    logic [H_W-1:0]   h_reg, h_next;
    logic [IDX_W-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [H_W-1:0]   top_reg, top_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    sample_t          out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic [IDX_W-1:0] seen_inc;
    logic [IDX_W-1:0] h_ext;
    logic [IDX_W-1:0] two_h_cfg;
    logic [IDX_W-1:0] two_h;
    logic             emit_main;
    logic             use_med;
    logic             out_free;
    logic             sort_clear;
    link_t            feed;
    sample_t          rd_data;
    sample_t          med_value;

    assign accept    = sample_ch.valid && sample_ch.ready;
    assign seen_inc  = (seen_reg < IDX_W'(DEPTH)) ? seen_reg + IDX_W'(1) : seen_reg;
    assign h_ext     = {1'b0, half_width_reg};
    assign two_h_cfg = {half_width_reg, 1'b0};
    assign two_h     = {h_reg, 1'b0};
    assign emit_main = seen_inc > h_ext;
    assign use_med   = seen_inc > two_h_cfg;
    assign out_free  = !out_valid_reg || result_ch.ready;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign sort_clear      = accept;
    assign feed            = {(state_reg == ST_FEED), rd_data};

    smf_window u_window
    (
        .clk        (clk),
        .shift_en   (accept),
        .shift_data (sample_ch.sample),
        .rd_idx     (rd_idx_reg),
        .rd_data    (rd_data)
    );

    smf_sorter u_sorter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (sort_clear),
        .feed  (feed),
        .rank  ({1'b0, h_reg}),
        .pick  (med_value)
    );

    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        seen_next      = seen_reg;
        rd_idx_next    = rd_idx_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    h_next    = half_width_reg;
                    last_next = sample_ch.end_of_signal;
                    seen_next = sample_ch.end_of_signal ? '0 : seen_inc;
                    top_next  = emit_main ? half_width_reg : seen_inc[H_W-1:0];
                    cnt_next  = '0;
                    if (use_med)
                    begin
                        state_next  = ST_FEED;
                        rd_idx_next = '0;
                    end
                    else if (emit_main)
                    begin
                        state_next  = ST_PASS;
                        rd_idx_next = h_ext;
                    end
                    else if (sample_ch.end_of_signal)
                    begin
                        state_next  = ST_TAIL;
                        rd_idx_next = seen_inc - IDX_W'(1);
                    end
                end
            end
            ST_FEED:
            begin
                if (cnt_reg == two_h)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next    = cnt_reg + IDX_W'(1);
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // let the last fed value ripple to its place
                if (cnt_reg == two_h)
                begin
                    state_next = ST_MED;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_MED, ST_PASS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = (state_reg == ST_MED) ? med_value : rd_data;
                    out_last_next  = last_reg && (top_reg == '0);
                    if (last_reg && (top_reg != '0))
                    begin
                        state_next  = ST_TAIL;
                        rd_idx_next = {1'b0, top_reg} - IDX_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = rd_data;
                    out_last_next  = (rd_idx_reg == '0);
                    if (rd_idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_idx_next = rd_idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            half_width_reg <= HALF_WIDTH_RST;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
            h_reg          <= '0;
            rd_idx_reg     <= '0;
            cnt_reg        <= '0;
            top_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
            rd_idx_reg    <= rd_idx_next;
            cnt_reg       <= cnt_next;
            top_reg       <= top_next;
            last_reg      <= last_next;
            if (cfg_we)
            begin
                half_width_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.value    = out_value_reg;
    assign result_ch.last_out = out_last_reg;
endmodule

/* dv/sliding_median_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_median_filter_tb
// Self-checking bench for the running median filter. A driver and a receiver
// move samples and filtered results with random idle bursts. A monitor keeps
// its own sample window and count, predicts every filtered sample with its
// last flag, and compares results in order. Several half widths are used,
// including 0 and 15. One half width change falls in the middle of a signal.
// ----------------------------------------------------------------------------
module sliding_median_filter_tb;
    import smf_pkg::*;

    localparam int PERIOD_HALF  = 10;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 250;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        sample_t sample;
        logic    eos;
    } filt_sample_t;

    typedef struct packed {
        sample_t value;
        logic    last;
    } filt_result_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_we;
    logic [H_W-1:0] cfg_wdata;

    smf_in_if  sample_ch ();
    smf_out_if result_ch ();

    sliding_median_filter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    sample_t        win_store [DEPTH];
    int             seen_cnt;
    logic [H_W-1:0] cur_half;

    filt_sample_t samples_to_send [$];
    filt_result_t filtered_due    [$];

    int   mismatches  = 0;
    logic in_taken    = 1'b0;
    int   tx_gap      = 0;
    int   rx_gap      = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_request = 1'b0;
    logic rx_hold      = 1'b0;
    filt_sample_t tx_item;

    always
    begin
        #PERIOD_HALF clk = 1'b1;
        #PERIOD_HALF clk = 1'b0;
    end

    function automatic sample_t window_median(int h);
        sample_t srt [DEPTH];
        sample_t x;
        int      i;
        int      j;
        for (i = 0; i < 2 * h + 1; i++)
        begin
            x = win_store[i];
            j = i;
            while (j > 0 && srt[j - 1] > x)
            begin
                srt[j] = srt[j - 1];
                j--;
            end
            srt[j] = x;
        end
        return srt[h];
    endfunction

    task automatic predict_filtered(input sample_t s, input logic eos);
        filt_result_t produced [$];
        filt_result_t r;
        int           h;
        int           top;
        int           i;
        h = int'(cur_half);
        if (h > MAX_HALF)
            h = MAX_HALF;
        for (i = DEPTH - 1; i > 0; i--)
            win_store[i] = win_store[i - 1];
        win_store[0] = s;
        if (seen_cnt < DEPTH)
            seen_cnt++;
        // result for the sample h positions back
        if (seen_cnt > h)
        begin
            r.last  = 1'b0;
            r.value = (seen_cnt > 2 * h) ? window_median(h) : win_store[h];
            produced.push_back(r);
        end
        if (eos)
        begin
            // flush the tail as pass-through, oldest first
            top = (seen_cnt > h) ? h : seen_cnt;
            while (top > 0)
            begin
                top--;
                r.value = win_store[top];
                r.last  = 1'b0;
                produced.push_back(r);
            end
            if (produced.size() > 0)
                produced[produced.size() - 1].last = 1'b1;
            seen_cnt = 0;
        end
        foreach (produced[k])
            filtered_due.push_back(produced[k]);
    endtask

    // monitor: check results, then predict from the accepted sample
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (filtered_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("[%0t] unexpected result value %0d last %0b", $realtime,
                                 result_ch.value, result_ch.last_out);
                end
                else
                begin
                    automatic filt_result_t e = filtered_due.pop_front();
                    if (result_ch.value !== e.value || result_ch.last_out !== e.last)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("[%0t] result value exp %0d got %0d, last exp %0b got %0b",
                                     $realtime, e.value, result_ch.value, e.last,
                                     result_ch.last_out);
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                predict_filtered(sample_ch.sample, sample_ch.end_of_signal);
        end
        in_taken <= rst_n && sample_ch.valid && sample_ch.ready;
    end

    // driver: hold the item until its transaction completes
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (in_taken || !sample_ch.valid)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                sample_ch.valid <= 1'b0;
            end
            else if (samples_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                tx_item = samples_to_send.pop_front();
                sample_ch.valid         <= 1'b1;
                sample_ch.sample        <= tx_item.sample;
                sample_ch.end_of_signal <= tx_item.eos;
            end
            else
            begin
                if (samples_to_send.size() > 0)
                    tx_gap = $urandom_range(9);
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n || rx_hold)
            result_ch.ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(99) < rx_idle_pct)
        begin
            rx_gap = $urandom_range(9);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // long receiver hold-off so the block backs up into the sample channel
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0:       return sample_t'(16'h8000);
            1:       return sample_t'(16'h7fff);
            2, 3:    return sample_t'(int'($urandom_range(6)) - 3);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic queue_signal(input int len);
        filt_sample_t it;
        for (int i = 0; i < len; i++)
        begin
            it.sample = rand_sample();
            it.eos    = (i == len - 1);
            samples_to_send.push_back(it);
        end
    endtask

    task automatic queue_fixed(input sample_t s, input logic eos);
        filt_sample_t it;
        it.sample = s;
        it.eos    = eos;
        samples_to_send.push_back(it);
    endtask

    // wait until the block has drained every expected result
    task automatic settle();
        while (samples_to_send.size() > 0 || sample_ch.valid || filtered_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_half(input logic [H_W-1:0] h);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cur_half = h;
    endtask

    initial
    begin
        int phase_half [7];
        int budget;
        int len;
        int pct_pick [3];

        phase_half = '{1, 3, 0, 7, 15, 2, 5};
        pct_pick   = '{0, 20, 45};

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_wdata               = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.sample        = '0;
        sample_ch.end_of_signal = 1'b0;
        result_ch.ready         = 1'b0;
        cur_half                = HALF_WIDTH_RST;
        seen_cnt                = 0;
        foreach (win_store[i])
            win_store[i] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes at the reset half width
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_fixed(sample_t'(16'h8000), 1'b0);
        queue_fixed(sample_t'(16'h7fff), 1'b0);
        queue_fixed(sample_t'(0), 1'b0);
        queue_fixed(sample_t'(-1), 1'b0);
        queue_fixed(sample_t'(1), 1'b0);
        queue_fixed(sample_t'(16'h7fff), 1'b0);
        queue_fixed(sample_t'(16'h8000), 1'b1);
        // one-sample signal
        queue_fixed(sample_t'(5), 1'b1);
        settle();

        // zero half width: pure pass-through
        write_half(H_W'(0));
        queue_fixed(sample_t'(16'h7fff), 1'b0);
        queue_fixed(sample_t'(16'h8000), 1'b1);
        settle();

        // half width changed in the middle of a signal
        write_half(H_W'(1));
        queue_fixed(sample_t'(7), 1'b0);
        queue_fixed(sample_t'(-7), 1'b0);
        queue_fixed(sample_t'(3), 1'b0);
        settle();
        write_half(H_W'(3));
        queue_fixed(sample_t'(16'h8000), 1'b0);
        queue_fixed(sample_t'(2), 1'b0);
        queue_fixed(sample_t'(16'h7fff), 1'b1);
        settle();

        // widest window, signal shorter than the window
        write_half(H_W'(15));
        queue_fixed(sample_t'(100), 1'b0);
        queue_fixed(sample_t'(-100), 1'b0);
        queue_fixed(sample_t'(0), 1'b1);
        settle();

        // random signals, one half width per phase
        foreach (phase_half[p])
        begin
            write_half(H_W'(phase_half[p]));
            if (p == $size(phase_half) - 1)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = pct_pick[$urandom_range(2)];
                rx_idle_pct = pct_pick[$urandom_range(2)];
            end
            if (p == 0)
                hold_request = 1'b1;
            budget = (phase_half[p] == MAX_HALF) ? 36 : 16;
            // first signal always long enough to reach full windows
            len = 2 * phase_half[p] + 1 + $urandom_range(6);
            while (budget > 0)
            begin
                if (len > budget)
                    len = budget;
                queue_signal(len);
                budget -= len;
                len = $urandom_range(1, 2 * phase_half[p] + 8);
            end
            settle();
        end

        if (mismatches == 0 && filtered_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
